/* sv/rmj_pkg.sv */
// ----------------------------------------------------------------------------
// rmj_pkg - shared types and helpers for the radar measurement Jacobian
// Word widths, per-cell payload structs, the divide step and the output
// saturation used by the root cells, divide cells and the top level.
// ----------------------------------------------------------------------------
package rmj_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CSR_W      = 16;
   localparam logic [CSR_W-1:0] THR_RESET = CSR_W'(7);

   localparam int SQ_W      = 2 * DATA_WIDTH;      // r squared, cross term
   localparam int RT_W      = DATA_WIDTH;          // integer root
   localparam int SQR_REM_W = RT_W + 2;            // root remainder
   localparam int DEN_W     = SQ_W + RT_W;         // r cubed
   localparam int NUM_W     = DEN_W + DATA_WIDTH;  // widest numerator
   localparam int QUO_W     = DATA_WIDTH;          // quotient bits kept
   localparam int SQRT_STEPS = RT_W;
   localparam int DIV_STEPS  = QUO_W;

   localparam int NUM_LANES  = 6;
   localparam int LANE_RNG_X = 0;
   localparam int LANE_RNG_Y = 1;
   localparam int LANE_BRG_X = 2;
   localparam int LANE_BRG_Y = 3;
   localparam int LANE_RTE_X = 4;
   localparam int LANE_RTE_Y = 5;

   // one divider lane, one quotient bit per cell
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nlo;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } rmj_lane_type;

   typedef struct packed {
      rmj_lane_type [NUM_LANES-1:0] lane;
      logic                         degen;
   } rmj_div_type;

   typedef struct packed {
      logic [SQ_W-1:0]       sq;      // radicand, shifted two bits a cell
      logic [SQ_W-1:0]       s_sum;
      logic [SQR_REM_W-1:0]  rem;
      logic [RT_W-1:0]       root;
      logic [DATA_WIDTH-1:0] ax;
      logic [DATA_WIDTH-1:0] ay;
      logic                  nx;
      logic                  ny;
      logic [SQ_W-1:0]       cmag;
      logic                  cneg;
      logic                  degen;
   } rmj_sq_type;

   typedef struct packed {
      logic [SQ_W-1:0]       sr_lo;
      logic [SQ_W-1:0]       sr_hi;
      logic [SQ_W-1:0]       yc_lo;
      logic [SQ_W-1:0]       yc_hi;
      logic [SQ_W-1:0]       xc_lo;
      logic [SQ_W-1:0]       xc_hi;
      logic [SQ_W-1:0]       s_sum;
      logic [RT_W-1:0]       root;
      logic [DATA_WIDTH-1:0] ax;
      logic [DATA_WIDTH-1:0] ay;
      logic                  nx;
      logic                  ny;
      logic                  cneg;
      logic                  degen;
   } rmj_mul_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] range_dpx;
      logic [DATA_WIDTH-1:0] range_dpy;
      logic [DATA_WIDTH-1:0] bearing_dpx;
      logic [DATA_WIDTH-1:0] bearing_dpy;
      logic [DATA_WIDTH-1:0] rate_dpx;
      logic [DATA_WIDTH-1:0] rate_dpy;
      logic                  degenerate;
   } rmj_rsp_type;

   function automatic rmj_lane_type make_lane(input logic [NUM_W-1:0] num,
                                              input logic [DEN_W-1:0] den,
                                              input logic             neg);
      rmj_lane_type l;
      l.rem = num[NUM_W-1:QUO_W];
      l.nlo = num[QUO_W-1:0];
      l.den = den;
      l.quo = '0;
      l.ovf = (num[NUM_W-1:QUO_W] >= den);
      l.neg = neg;
      return l;
   endfunction

   // restoring divide: bring down one numerator bit, subtract if it fits
   function automatic rmj_lane_type div_step(input rmj_lane_type l);
      rmj_lane_type    o;
      logic [DEN_W:0]  t;
      logic [DEN_W:0]  d;
      logic            ge;
      t  = {l.rem, l.nlo[QUO_W-1]};
      d  = {1'b0, l.den};
      ge = (t >= d);
      o  = l;
      o.rem = ge ? DEN_W'(t - d) : t[DEN_W-1:0];
      o.nlo = {l.nlo[QUO_W-2:0], 1'b0};
      o.quo = {l.quo[QUO_W-2:0], ge};
      return o;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] sat_word(input rmj_lane_type l);
      logic [QUO_W-1:0] lim;
      logic [QUO_W-1:0] v;
      lim = l.neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
      v   = (l.ovf || (l.quo > lim)) ? lim : l.quo;
      return l.neg ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
   endfunction

endpackage

/* sv/radar_measurement_jacobian.sv */
// ----------------------------------------------------------------------------
// radar_measurement_jacobian - EKF radar measurement Jacobian
// Track state in, six distinct Jacobian entries and a degenerate flag out.
// ----------------------------------------------------------------------------
// Input words (position and velocity, signed Q16.16) arrive on req_valid /
// req_stall; result words leave on rsp_valid / rsp_stall. A word moves at a
// clock edge where valid is high and stall is low.
// One word is taken every cycle while req_stall is low. The chain holds two product stages,
// 32 root cells (one root bit each), two stages for r cubed and the
// range-rate numerators, 32 divide cells (one quotient bit each, six lanes
// side by side) and the output register.
// A skid register behind the output register takes one more word while
// the receiver stalls; once it is full, req_stall rises and the whole
// chain holds until the receiver takes a word.
// csr_wr_en / csr_wr_data set the threshold on r squared (Q16.16, so the
// reset value of 7 is roughly 0.0001); write it only while the block is
// empty.
// Synchronous reset empties the chain and the output side and loads a
// threshold of 7.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] req_pos_x,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] req_pos_y,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] req_vel_x,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] req_vel_y,
   input  logic                                  csr_wr_en,
   input  logic [rmj_pkg::CSR_W-1:0]             csr_wr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_range_dpx,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_range_dpy,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_bearing_dpx,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_bearing_dpy,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_rate_dpx,
   output logic signed [rmj_pkg::DATA_WIDTH-1:0] rsp_rate_dpy,
   output logic                                  rsp_degenerate
);
   import rmj_pkg::*;

   logic [CSR_W-1:0] thr_ff;
   logic             out_v_ff, skid_v_ff;
   rmj_rsp_type      out_ff, skid_ff, res;
   logic             adv, produce, out_free;

   rmj_sq_type       sq_w [0:SQRT_STEPS];
   logic             sq_v [0:SQRT_STEPS];
   rmj_div_type      dv_w [0:DIV_STEPS];
   logic             dv_v [0:DIV_STEPS];

   // the chain holds only while a word sits in the skid register
   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   rmj_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .thr       (thr_ff),
      .out_valid (sq_v[0]),
      .out_word  (sq_w[0])
   );

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      rmj_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[i]),
         .in_word   (sq_w[i]),
         .out_valid (sq_v[i+1]),
         .out_word  (sq_w[i+1])
      );
   end

   rmj_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_v[SQRT_STEPS]),
      .in_word   (sq_w[SQRT_STEPS]),
      .out_valid (dv_v[0]),
      .out_word  (dv_w[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rmj_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_v[i]),
         .in_word   (dv_w[i]),
         .out_valid (dv_v[i+1]),
         .out_word  (dv_w[i+1])
      );
   end

   always_comb begin
      res.degenerate = dv_w[DIV_STEPS].degen;
      if (dv_w[DIV_STEPS].degen) begin
         res.range_dpx   = '0;
         res.range_dpy   = '0;
         res.bearing_dpx = '0;
         res.bearing_dpy = '0;
         res.rate_dpx    = '0;
         res.rate_dpy    = '0;
      end else begin
         res.range_dpx   = sat_word(dv_w[DIV_STEPS].lane[LANE_RNG_X]);
         res.range_dpy   = sat_word(dv_w[DIV_STEPS].lane[LANE_RNG_Y]);
         res.bearing_dpx = sat_word(dv_w[DIV_STEPS].lane[LANE_BRG_X]);
         res.bearing_dpy = sat_word(dv_w[DIV_STEPS].lane[LANE_BRG_Y]);
         res.rate_dpx    = sat_word(dv_w[DIV_STEPS].lane[LANE_RTE_X]);
         res.rate_dpy    = sat_word(dv_w[DIV_STEPS].lane[LANE_RTE_Y]);
      end
   end

   assign produce  = dv_v[DIV_STEPS] && adv;
   assign out_free = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (out_free) begin
            out_v_ff  <= skid_v_ff || produce;
            skid_v_ff <= 1'b0;
         end else if (produce) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   // drain the skid word first, else take the word leaving the chain
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (produce) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_range_dpx   = out_ff.range_dpx;
   assign rsp_range_dpy   = out_ff.range_dpy;
   assign rsp_bearing_dpx = out_ff.bearing_dpx;
   assign rsp_bearing_dpy = out_ff.bearing_dpy;
   assign rsp_rate_dpx    = out_ff.rate_dpx;
   assign rsp_rate_dpy    = out_ff.rate_dpy;
   assign rsp_degenerate  = out_ff.degenerate;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held with output register empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_stall) |=> (rsp_valid && !skid_v_ff))
      else $error("skid word not moved to output");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_range_dpx == '0 && rsp_range_dpy == '0
         && rsp_bearing_dpx == '0 && rsp_bearing_dpy == '0
         && rsp_rate_dpx == '0 && rsp_rate_dpy == '0))
      else $error("degenerate word with nonzero entry");

endmodule

/* sv/rmj_front.sv */
// ----------------------------------------------------------------------------
// rmj_front - squares, cross products and range check
// Two register stages: signed products, then r squared, the cross term
// magnitude and sign, and the small-range flag. Feeds the first root cell.
// ----------------------------------------------------------------------------
module rmj_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] pos_x,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] pos_y,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] vel_x,
   input  logic signed [rmj_pkg::DATA_WIDTH-1:0] vel_y,
   input  logic [rmj_pkg::CSR_W-1:0]           thr,
   output logic                                out_valid,
   output rmj_pkg::rmj_sq_type                 out_word
);
   import rmj_pkg::*;

   logic                   v1_ff, v2_ff;
   logic signed [SQ_W-1:0] sqx_ff, sqy_ff, p1_ff, p2_ff;
   logic [DATA_WIDTH-1:0]  ax_ff, ay_ff;
   logic                   nx_ff, ny_ff;
   rmj_sq_type             w2_ff, w2_in;

   logic [SQ_W-1:0]        s_sum;
   logic [SQ_W:0]          c_full;
   logic [SQ_W-1:0]        thr_wide;

   always_comb begin
      s_sum    = sqx_ff + sqy_ff;
      c_full   = {p1_ff[SQ_W-1], p1_ff} - {p2_ff[SQ_W-1], p2_ff};
      thr_wide = SQ_W'(thr) << FRAC_BITS;
      w2_in.sq    = s_sum;
      w2_in.s_sum = s_sum;
      w2_in.rem   = '0;
      w2_in.root  = '0;
      w2_in.ax    = ax_ff;
      w2_in.ay    = ay_ff;
      w2_in.nx    = nx_ff;
      w2_in.ny    = ny_ff;
      w2_in.cneg  = c_full[SQ_W];
      w2_in.cmag  = c_full[SQ_W] ? SQ_W'(-c_full) : c_full[SQ_W-1:0];
      w2_in.degen = (s_sum == '0) || (s_sum < thr_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= pos_x * pos_x;
         sqy_ff <= pos_y * pos_y;
         p1_ff  <= vel_x * pos_y;
         p2_ff  <= vel_y * pos_x;
         ax_ff  <= pos_x[DATA_WIDTH-1] ? DATA_WIDTH'(-pos_x) : pos_x;
         ay_ff  <= pos_y[DATA_WIDTH-1] ? DATA_WIDTH'(-pos_y) : pos_y;
         nx_ff  <= pos_x[DATA_WIDTH-1];
         ny_ff  <= pos_y[DATA_WIDTH-1];
         w2_ff  <= w2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_word  = w2_ff;

endmodule

/* sv/rmj_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmj_sqrt_cell - one root bit
// Digit-by-digit integer square root: brings down two radicand bits, tries
// the next root bit and passes the partial root and remainder on.
// ----------------------------------------------------------------------------
module rmj_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rmj_pkg::rmj_sq_type in_word,
   output logic                out_valid,
   output rmj_pkg::rmj_sq_type out_word
);
   import rmj_pkg::*;

   logic                 v_ff;
   rmj_sq_type           w_ff, w_in;
   logic [SQR_REM_W+1:0] rem_t, trial;
   logic                 fits;

   always_comb begin
      rem_t = {in_word.rem, in_word.sq[SQ_W-1 -: 2]};
      trial = (SQR_REM_W+2)'({in_word.root, 2'b01});
      fits  = (rem_t >= trial);
      w_in      = in_word;
      w_in.sq   = {in_word.sq[SQ_W-3:0], 2'b00};
      w_in.rem  = fits ? SQR_REM_W'(rem_t - trial) : rem_t[SQR_REM_W-1:0];
      w_in.root = {in_word.root[RT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = w_ff;

endmodule

/* sv/rmj_prod.sv */
// ----------------------------------------------------------------------------
// rmj_prod - r cubed and range-rate numerators
// Half-width partial products in one stage, their sums and the divider
// lane set-up (numerators, divisors, overflow check, signs) in the next.
// ----------------------------------------------------------------------------
module rmj_prod (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  rmj_pkg::rmj_sq_type  in_word,
   output logic                 out_valid,
   output rmj_pkg::rmj_div_type out_word
);
   import rmj_pkg::*;

   logic         v1_ff, v2_ff;
   rmj_mul_type  m_ff, m_in;
   rmj_div_type  d_ff, d_in;
   logic [DEN_W-1:0] den, num_y, num_x;

   always_comb begin
      m_in.sr_lo = in_word.s_sum[DATA_WIDTH-1:0] * in_word.root;
      m_in.sr_hi = in_word.s_sum[SQ_W-1:DATA_WIDTH] * in_word.root;
      m_in.yc_lo = in_word.ay * in_word.cmag[DATA_WIDTH-1:0];
      m_in.yc_hi = in_word.ay * in_word.cmag[SQ_W-1:DATA_WIDTH];
      m_in.xc_lo = in_word.ax * in_word.cmag[DATA_WIDTH-1:0];
      m_in.xc_hi = in_word.ax * in_word.cmag[SQ_W-1:DATA_WIDTH];
      m_in.s_sum = in_word.s_sum;
      m_in.root  = in_word.root;
      m_in.ax    = in_word.ax;
      m_in.ay    = in_word.ay;
      m_in.nx    = in_word.nx;
      m_in.ny    = in_word.ny;
      m_in.cneg  = in_word.cneg;
      m_in.degen = in_word.degen;
   end

   always_comb begin
      den   = DEN_W'(m_ff.sr_lo) + (DEN_W'(m_ff.sr_hi) << DATA_WIDTH);
      num_y = DEN_W'(m_ff.yc_lo) + (DEN_W'(m_ff.yc_hi) << DATA_WIDTH);
      num_x = DEN_W'(m_ff.xc_lo) + (DEN_W'(m_ff.xc_hi) << DATA_WIDTH);
      d_in.degen = m_ff.degen;
      d_in.lane[LANE_RNG_X] = make_lane(NUM_W'(m_ff.ax) << FRAC_BITS,
                                        DEN_W'(m_ff.root), m_ff.nx);
      d_in.lane[LANE_RNG_Y] = make_lane(NUM_W'(m_ff.ay) << FRAC_BITS,
                                        DEN_W'(m_ff.root), m_ff.ny);
      d_in.lane[LANE_BRG_X] = make_lane(NUM_W'(m_ff.ay) << (2*FRAC_BITS),
                                        DEN_W'(m_ff.s_sum), !m_ff.ny);
      d_in.lane[LANE_BRG_Y] = make_lane(NUM_W'(m_ff.ax) << (2*FRAC_BITS),
                                        DEN_W'(m_ff.s_sum), m_ff.nx);
      d_in.lane[LANE_RTE_X] = make_lane(NUM_W'(num_y) << FRAC_BITS, den,
                                        m_ff.ny != m_ff.cneg);
      d_in.lane[LANE_RTE_Y] = make_lane(NUM_W'(num_x) << FRAC_BITS, den,
                                        m_ff.nx == m_ff.cneg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         d_ff <= d_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_word  = d_ff;

endmodule

/* sv/rmj_div_cell.sv */
// ----------------------------------------------------------------------------
// rmj_div_cell - one quotient bit for all six lanes
// Each lane brings down one numerator bit and subtracts its divisor where
// it fits; the quotient bit shifts in at the bottom.
// ----------------------------------------------------------------------------
module rmj_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  rmj_pkg::rmj_div_type in_word,
   output logic                 out_valid,
   output rmj_pkg::rmj_div_type out_word
);
   import rmj_pkg::*;

   logic        v_ff;
   rmj_div_type w_ff, w_in;

   always_comb begin
      w_in.degen = in_word.degen;
      for (int k = 0; k < NUM_LANES; k++) begin
         w_in.lane[k] = div_step(in_word.lane[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = w_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - radar measurement Jacobian regression
// Drives random and directed track states through the block under random
// idling and receiver stalls, and predicts every Jacobian word in wide
// exact integer arithmetic. Results are checked in order against the
// predictions. The range-squared threshold is changed between phases.
// ----------------------------------------------------------------------------
class jacobian_scoreboard;
   rmj_pkg::rmj_rsp_type pending[$];
   int                   errors;
   int                   checked;
   int                   degen_seen;

   function new();
      errors     = 0;
      checked    = 0;
      degen_seen = 0;
   endfunction

   // split a signed word into sign and magnitude
   function automatic logic [127:0] magnitude(input logic [31:0] v, output logic neg);
      logic [32:0] m;
      neg = v[31];
      m   = neg ? (33'd0 - {1'b1, v}) : {1'b0, v};
      return 128'(m);
   endfunction

   function automatic logic [127:0] root_floor(input logic [127:0] s);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= s) r = c;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp_quotient(input logic [127:0] n,
                                                  input logic [127:0] d,
                                                  input logic neg);
      logic [127:0] q;
      logic [127:0] lim;
      q   = n / d;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? 32'(-q[31:0]) : q[31:0];
   endfunction

   function automatic rmj_pkg::rmj_rsp_type jacobian_of(input logic [31:0] px,
         input logic [31:0] py, input logic [31:0] vx, input logic [31:0] vy,
         input logic [15:0] thr);
      rmj_pkg::rmj_rsp_type o;
      logic [127:0] ax, ay, avx, avy, s, r, p1, p2, c, den;
      logic         nx, ny, nvx, nvy, s1, s2, cneg;
      ax  = magnitude(px, nx);
      ay  = magnitude(py, ny);
      avx = magnitude(vx, nvx);
      avy = magnitude(vy, nvy);
      s   = ax * ax + ay * ay;
      o   = '0;
      if (s == 0 || s < (128'(thr) << 16)) begin
         o.degenerate = 1'b1;
         return o;
      end
      r = root_floor(s);
      o.range_dpx   = clamp_quotient(ax << 16, r, nx);
      o.range_dpy   = clamp_quotient(ay << 16, r, ny);
      o.bearing_dpx = clamp_quotient(ay << 32, s, !ny);
      o.bearing_dpy = clamp_quotient(ax << 32, s, nx);
      // cross term vx*py - vy*px as sign and magnitude
      p1 = avx * ay;
      s1 = nvx ^ ny;
      p2 = avy * ax;
      s2 = !(nvy ^ nx);
      if (s1 == s2) begin
         c = p1 + p2; cneg = s1;
      end else if (p1 >= p2) begin
         c = p1 - p2; cneg = s1;
      end else begin
         c = p2 - p1; cneg = s2;
      end
      den = s * r;
      o.rate_dpx = clamp_quotient((ay * c) << 16, den, ny ^ cneg);
      o.rate_dpy = clamp_quotient((ax * c) << 16, den, nx ^ !cneg);
      return o;
   endfunction

   function void note_state(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] vx, input logic [31:0] vy,
                            input logic [15:0] thr);
      pending.push_back(jacobian_of(px, py, vx, vy, thr));
   endfunction

   function void check_word(input rmj_pkg::rmj_rsp_type got);
      rmj_pkg::rmj_rsp_type want;
      logic [31:0] w[7];
      logic [31:0] g[7];
      string       label[7];
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, got);
         errors++;
         return;
      end
      want  = pending.pop_front();
      checked++;
      if (want.degenerate) degen_seen++;
      label = '{"range_dpx", "range_dpy", "bearing_dpx", "bearing_dpy",
                "rate_dpx", "rate_dpy", "degenerate"};
      w = '{want.range_dpx, want.range_dpy, want.bearing_dpx, want.bearing_dpy,
            want.rate_dpx, want.rate_dpy, 32'(want.degenerate)};
      g = '{got.range_dpx, got.range_dpy, got.bearing_dpx, got.bearing_dpy,
            got.rate_dpx, got.rate_dpy, 32'(got.degenerate)};
      for (int i = 0; i < 7; i++)
         if (w[i] !== g[i]) begin
            $display("%0t: %s expected %h actual %h", $time, label[i], w[i], g[i]);
            errors++;
         end
   endfunction
endclass

module testbench;
   import rmj_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_range_dpx, rsp_range_dpy, rsp_bearing_dpx, rsp_bearing_dpy;
   logic [31:0] rsp_rate_dpx, rsp_rate_dpy;
   logic        rsp_degenerate;

   logic [15:0] threshold;
   logic        steady;
   int          cycles;
   int          sent;

   jacobian_scoreboard board = new();

   radar_measurement_jacobian DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_range_dpx(rsp_range_dpx), .rsp_range_dpy(rsp_range_dpy),
      .rsp_bearing_dpx(rsp_bearing_dpx), .rsp_bearing_dpy(rsp_bearing_dpy),
      .rsp_rate_dpx(rsp_rate_dpx), .rsp_rate_dpy(rsp_rate_dpy),
      .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall)
         board.note_state(req_pos_x, req_pos_y, req_vel_x, req_vel_y, threshold);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word({rsp_range_dpx, rsp_range_dpy, rsp_bearing_dpx,
                           rsp_bearing_dpy, rsp_rate_dpx, rsp_rate_dpy,
                           rsp_degenerate});
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stalls at random, except during the steady stretch
   always @(negedge clock)
      rsp_stall <= !steady && ($urandom_range(0, 99) < 9);

   task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy);
      if (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // drop valid, drain, allow for words still in flight, then write
   task automatic set_threshold(input logic [15:0] value);
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      threshold   <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return 32'($signed($urandom_range(0, 8191)) - 4096);
         3:       return 32'($signed($urandom_range(0, 2097151)) - 1048576);
         4:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [15:0] phase_thr[4];
      cycles      = 0;
      sent        = 0;
      steady      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_vel_x   = '0;
      req_vel_y   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      rsp_stall   = 1'b0;
      threshold   = THR_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners at the reset threshold
      send_state(32'h0, 32'h0, 32'h0, 32'h0);
      send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_state(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_state(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_state(32'h1, 32'h0, 32'h1, 32'h1);
      send_state(32'd677, 32'h0, 32'h10000, 32'h0);
      send_state(32'd678, 32'h0, 32'h10000, 32'h0);
      send_state(-32'd678, 32'd3, 32'hFFFF_0000, 32'h0001_0000);
      send_state(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
      send_state(32'h0, -32'sh0001_0000, 32'h0003_0000, 32'h0);
      send_state(32'h0003_0000, 32'h0004_0000, -32'sh0002_0000, 32'h0005_0000);
      send_state(32'h0000_0400, 32'hFFFF_FC00, 32'h7FFF_FFFF, 32'h8000_0000);
      send_state(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

      phase_thr = '{16'd0, 16'hFFFF, 16'($urandom), THR_RESET};
      for (int p = 0; p < 4; p++) begin
         set_threshold(phase_thr[p]);
         if (p == 0) send_state(32'h0, 32'h0, 32'h1, 32'h1);
         if (p == 0) send_state(32'h1, 32'h0, 32'h1, 32'h1);
         for (int i = 0; i < 260; i++) begin
            steady = (p == 2) && (i >= 40) && (i < 200);
            send_state(random_coord(), random_coord(), random_coord(), random_coord());
         end
         steady = 1'b0;
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      $display("Sent %0d track states over four threshold settings (0, max, random, 7).",
               sent);
      $display("Checked %0d Jacobian words, %0d of them degenerate.",
               board.checked, board.degen_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
